// ===== design/cpa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cpa_pkg;

  localparam int PART_DEPTH = 128;
  localparam int IDX_W      = 7;
  localparam int CNT_W      = 8;
  localparam int SIZE_W     = 8;
  localparam int OWNER_W    = 8;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  // register index, taken from paddr[2]
  localparam logic REG_FIT_MODE = 1'b0;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  localparam logic CMD_ALLOC  = 1'b0;
  localparam logic CMD_REINIT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_SCAN,
    ST_APPLY,
    ST_REINIT,
    ST_EMIT
  } cpa_state_t;

  typedef struct packed {
    logic               command;
    logic [SIZE_W-1:0]  request_size;
    logic [OWNER_W-1:0] owner_id;
  } cpa_in_t;

  typedef struct packed {
    logic             granted;
    logic [6:0]       start_block;
    logic [IDX_W-1:0] chosen_index;
    logic [CNT_W-1:0] partitions_used;
  } cpa_out_t;

  // table update broadcast from the controller to every cell
  typedef struct packed {
    logic               apply;
    logic               reinit;
    logic               split;
    logic [1:0]         fit_mode;
    logic [IDX_W-1:0]   pick_idx;
    logic [OWNER_W-1:0] owner;
    logic [CNT_W-1:0]   count;
  } cpa_ctl_t;

endpackage

`default_nettype wire

// ===== design/cpa_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cpa_cell #(
  parameter int IDX        = 0,
  parameter int MEM_BLOCKS = 128,
  parameter int SW         = 7,
  parameter int LW         = 8
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire  [cpa_pkg::SIZE_W-1:0] size,
  input  cpa_pkg::cpa_ctl_t          ctl,
  input  wire  [SW-1:0]              rem_start,
  input  wire  [LW-1:0]              rem_len,
  // entry of the cell below, for the shift
  input  wire  [SW-1:0]              prev_start,
  input  wire  [LW-1:0]              prev_len,
  input  wire                        prev_free,
  input  wire  [cpa_pkg::OWNER_W-1:0] prev_owner,
  output logic [SW-1:0]              ent_start,
  output logic [LW-1:0]              ent_len,
  output logic                       ent_free,
  output logic [cpa_pkg::OWNER_W-1:0] ent_owner,
  // search wave
  input  wire                        go_in,
  input  wire                        found_in,
  input  wire  [cpa_pkg::IDX_W-1:0]  idx_in,
  input  wire  [LW-1:0]              len_in,
  input  wire  [SW-1:0]              start_in,
  output logic                       go_out,
  output logic                       found_out,
  output logic [cpa_pkg::IDX_W-1:0]  idx_out,
  output logic [LW-1:0]              len_out,
  output logic [SW-1:0]              start_out
);
  import cpa_pkg::*;

  localparam int CW = (LW > SIZE_W) ? LW : SIZE_W;
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
  localparam logic [CNT_W-1:0] MY_POS = CNT_W'(IDX);

  logic             used;
  logic             fits;
  logic             better;
  logic             take;
  logic [CNT_W-1:0] above_k;
  logic             is_k;
  logic             is_rem;
  logic             is_shift;

  always_comb begin
    used   = MY_POS < ctl.count;
    fits   = used && ent_free && (CW'(ent_len) >= CW'(size));
    better = ((ctl.fit_mode == FIT_BEST) && (ent_len < len_in)) ||
             ((ctl.fit_mode == FIT_WORST) && (ent_len > len_in));
    take   = fits && (!found_in || better);

    above_k  = {1'b0, ctl.pick_idx} + CNT_W'(1);
    is_k     = MY_IDX == ctl.pick_idx;
    is_rem   = ctl.split && (MY_POS == above_k);
    is_shift = ctl.split && (MY_POS > above_k);
  end

  always_ff @(posedge clk) begin
    if ((IDX == 0) && (rst || ctl.reinit)) begin
      ent_start <= '0;
      ent_len   <= LW'(MEM_BLOCKS);
      ent_free  <= 1'b1;
      ent_owner <= '0;
    end else if (ctl.apply) begin
      if (is_k) begin
        ent_len   <= LW'(size);
        ent_free  <= 1'b0;
        ent_owner <= ctl.owner;
      end else if (is_rem) begin
        ent_start <= rem_start;
        ent_len   <= rem_len;
        ent_free  <= 1'b1;
        ent_owner <= '0;
      end else if (is_shift) begin
        ent_start <= prev_start;
        ent_len   <= prev_len;
        ent_free  <= prev_free;
        ent_owner <= prev_owner;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      go_out <= 1'b0;
    end else begin
      go_out <= go_in;
    end
  end

  always_ff @(posedge clk) begin
    if (go_in) begin
      found_out <= found_in || fits;
      if (take) begin
        idx_out   <= MY_IDX;
        len_out   <= ent_len;
        start_out <= ent_start;
      end else begin
        idx_out   <= idx_in;
        len_out   <= len_in;
        start_out <= start_in;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/contiguous_partition_allocator_core.sv =====
// Contiguous partition allocator.
// Request channel (req_valid / req_stall / req): one word carries a command,
// a size in blocks and an owner id. Response channel (rsp_valid / rsp_stall /
// rsp): exactly one word per request with granted, start block, table index
// and the number of partitions after the step.
// The table sits in a row of 128 cells. An allocate sends a search wave up the
// row, one cell per cycle, and the pick is known once the wave leaves the top
// cell; the split and shift of the table tail then happen in all cells at once.
// An allocate steps through launch, scan, apply and emit; a reinitialize
// through reinit and emit; a zero-size request goes to emit. One request
// is in work at a time; req_stall is high while a request is in work.
// The response sits in an output register: while rsp_stall holds it, the next
// request can already be accepted and worked on, and its response waits
// until the register is free.
// fit_mode lives at byte address 0 of the APB port (0 first, 1 best,
// 2 worst fit); write it only while the block is idle.
// Reset (rst, synchronous) restores one free partition over the whole
// memory, sets fit_mode to first fit and drops any pending response.
`timescale 1ns / 1ps
`default_nettype none

module contiguous_partition_allocator_core #(
  parameter int MEM_BLOCKS = 128
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          req_valid,
  output logic                         req_stall,
  input  cpa_pkg::cpa_in_t             req,
  output logic                         rsp_valid,
  input  wire                          rsp_stall,
  output cpa_pkg::cpa_out_t            rsp,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [cpa_pkg::PADDR_W-1:0]  paddr,
  input  wire  [cpa_pkg::PDATA_W-1:0]  pwdata,
  output logic [cpa_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import cpa_pkg::*;

  localparam int SW = (MEM_BLOCKS > 1) ? $clog2(MEM_BLOCKS) : 1;
  localparam int LW = $clog2(MEM_BLOCKS + 1);
  localparam int CW = (LW > SIZE_W) ? LW : SIZE_W;

  cpa_state_t       state, state_next;
  cpa_in_t          item, item_next;
  logic [CNT_W-1:0] count, count_next;
  logic             pick_found, pick_found_next;
  logic [IDX_W-1:0] pick_idx, pick_idx_next;
  logic [LW-1:0]    pick_len, pick_len_next;
  logic [SW-1:0]    pick_start, pick_start_next;
  cpa_out_t         res, res_next;
  logic             rsp_valid_next;
  cpa_out_t         rsp_next;
  logic [1:0]       fit_mode;
  cpa_ctl_t         ctl;
  logic             launch;
  logic             split;
  logic             full;
  logic [SW-1:0]    rem_start;
  logic [LW-1:0]    rem_len;

  // row wiring
  logic [SW-1:0]      c_start [PART_DEPTH];
  logic [LW-1:0]      c_len   [PART_DEPTH];
  logic               c_free  [PART_DEPTH];
  logic [OWNER_W-1:0] c_owner [PART_DEPTH];
  logic               w_go    [PART_DEPTH+1];
  logic               w_found [PART_DEPTH+1];
  logic [IDX_W-1:0]   w_idx   [PART_DEPTH+1];
  logic [LW-1:0]      w_len   [PART_DEPTH+1];
  logic [SW-1:0]      w_start [PART_DEPTH+1];

  assign w_go[0]    = launch;
  assign w_found[0] = 1'b0;
  assign w_idx[0]   = '0;
  assign w_len[0]   = '0;
  assign w_start[0] = '0;

  for (genvar i = 0; i < PART_DEPTH; i++) begin : g_row
    logic [SW-1:0]      p_start;
    logic [LW-1:0]      p_len;
    logic               p_free;
    logic [OWNER_W-1:0] p_owner;

    if (i == 0) begin : g_head
      assign p_start = '0;
      assign p_len   = '0;
      assign p_free  = 1'b0;
      assign p_owner = '0;
    end else begin : g_link
      assign p_start = c_start[i-1];
      assign p_len   = c_len[i-1];
      assign p_free  = c_free[i-1];
      assign p_owner = c_owner[i-1];
    end

    cpa_cell #(
      .IDX        (i),
      .MEM_BLOCKS (MEM_BLOCKS),
      .SW         (SW),
      .LW         (LW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .size       (item.request_size),
      .ctl        (ctl),
      .rem_start  (rem_start),
      .rem_len    (rem_len),
      .prev_start (p_start),
      .prev_len   (p_len),
      .prev_free  (p_free),
      .prev_owner (p_owner),
      .ent_start  (c_start[i]),
      .ent_len    (c_len[i]),
      .ent_free   (c_free[i]),
      .ent_owner  (c_owner[i]),
      .go_in      (w_go[i]),
      .found_in   (w_found[i]),
      .idx_in     (w_idx[i]),
      .len_in     (w_len[i]),
      .start_in   (w_start[i]),
      .go_out     (w_go[i+1]),
      .found_out  (w_found[i+1]),
      .idx_out    (w_idx[i+1]),
      .len_out    (w_len[i+1]),
      .start_out  (w_start[i+1])
    );
  end

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode <= FIT_FIRST;
    end else if (psel && penable && pwrite && (paddr[2] == REG_FIT_MODE)) begin
      fit_mode <= pwdata[1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_FIT_MODE) begin
      prdata = PDATA_W'(fit_mode);
    end
  end

  always_comb begin
    split     = CW'(pick_len) > CW'(item.request_size);
    full      = count >= CNT_W'(PART_DEPTH);
    rem_start = pick_start + SW'(item.request_size);
    rem_len   = pick_len - LW'(item.request_size);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= CNT_W'(1);
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    item       <= item_next;
    pick_found <= pick_found_next;
    pick_idx   <= pick_idx_next;
    pick_len   <= pick_len_next;
    pick_start <= pick_start_next;
    res        <= res_next;
    rsp        <= rsp_next;
  end

  always_comb begin
    state_next      = state;
    item_next       = item;
    count_next      = count;
    pick_found_next = pick_found;
    pick_idx_next   = pick_idx;
    pick_len_next   = pick_len;
    pick_start_next = pick_start;
    res_next        = res;
    rsp_next        = rsp;
    rsp_valid_next  = rsp_valid && rsp_stall;
    req_stall       = 1'b1;
    launch          = 1'b0;

    ctl          = '0;
    ctl.fit_mode = fit_mode;
    ctl.pick_idx = pick_idx;
    ctl.owner    = item.owner_id;
    ctl.count    = count;
    ctl.split    = split;

    case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          item_next = req;
          if (req.command == CMD_REINIT) begin
            state_next = ST_REINIT;
          end else if (req.request_size == '0) begin
            res_next                 = '0;
            res_next.partitions_used = count;
            state_next               = ST_EMIT;
          end else begin
            state_next = ST_LAUNCH;
          end
        end
      end
      ST_LAUNCH: begin
        launch     = 1'b1;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (w_go[PART_DEPTH]) begin
          pick_found_next = w_found[PART_DEPTH];
          pick_idx_next   = w_idx[PART_DEPTH];
          pick_len_next   = w_len[PART_DEPTH];
          pick_start_next = w_start[PART_DEPTH];
          state_next      = ST_APPLY;
        end
      end
      ST_APPLY: begin
        res_next = '0;
        if (pick_found && !(split && full)) begin
          ctl.apply                = 1'b1;
          count_next               = count + CNT_W'(split);
          res_next.granted         = 1'b1;
          res_next.start_block     = 7'(pick_start);
          res_next.chosen_index    = pick_idx;
          res_next.partitions_used = count + CNT_W'(split);
        end else begin
          res_next.partitions_used = count;
        end
        state_next = ST_EMIT;
      end
      ST_REINIT: begin
        ctl.reinit               = 1'b1;
        count_next               = CNT_W'(1);
        res_next                 = '0;
        res_next.partitions_used = CNT_W'(1);
        state_next               = ST_EMIT;
      end
      ST_EMIT: begin
        // hand over once the output register is free
        if (!rsp_valid || !rsp_stall) begin
          rsp_next       = res;
          rsp_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import cpa_pkg::*;

  localparam logic [1:0] FIT_SPARE = 2'd3;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 150;

  logic clk;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  cpa_in_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  cpa_out_t rsp;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  contiguous_partition_allocator_core u_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // predicted partition table
  bit [6:0] tbl_start [PART_DEPTH];
  bit [7:0] tbl_len [PART_DEPTH];
  bit tbl_free [PART_DEPTH];
  bit [7:0] tbl_owner [PART_DEPTH];
  bit [7:0] tbl_count;
  bit [1:0] fit_sel;

  cpa_out_t alloc_results_due [$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;
  int stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void table_reset();
    for (int i = 0; i < PART_DEPTH; i++) begin
      tbl_start[i] = '0;
      tbl_len[i] = '0;
      tbl_free[i] = 1'b0;
      tbl_owner[i] = '0;
    end
    tbl_len[0] = 8'd128;
    tbl_free[0] = 1'b1;
    tbl_count = 8'd1;
  endfunction

  function automatic cpa_out_t apply_request(cpa_in_t w);
    cpa_out_t r;
    int pick;
    int pick_len;
    bit ok;
    r = '0;
    pick = -1;
    pick_len = 0;
    if (w.command == CMD_REINIT) begin
      table_reset();
    end else if (w.request_size != '0) begin
      for (int i = 0; i < int'(tbl_count); i++) begin
        if (!tbl_free[i] || tbl_len[i] < w.request_size) continue;
        if (pick < 0) begin
          pick = i;
          pick_len = int'(tbl_len[i]);
          if (fit_sel != FIT_BEST && fit_sel != FIT_WORST) break;
        end else if (fit_sel == FIT_BEST && int'(tbl_len[i]) < pick_len) begin
          pick = i;
          pick_len = int'(tbl_len[i]);
        end else if (fit_sel == FIT_WORST && int'(tbl_len[i]) > pick_len) begin
          pick = i;
          pick_len = int'(tbl_len[i]);
        end
      end
      if (pick >= 0) begin
        ok = 1'b1;
        if (tbl_len[pick] > w.request_size) begin
          // split: tail moves up one slot, free remainder lands right after the pick
          if (int'(tbl_count) >= PART_DEPTH) begin
            ok = 1'b0;
          end else begin
            for (int j = int'(tbl_count); j > pick + 1; j--) begin
              tbl_start[j] = tbl_start[j-1];
              tbl_len[j] = tbl_len[j-1];
              tbl_free[j] = tbl_free[j-1];
              tbl_owner[j] = tbl_owner[j-1];
            end
            tbl_start[pick+1] = tbl_start[pick] + w.request_size[6:0];
            tbl_len[pick+1] = tbl_len[pick] - w.request_size;
            tbl_free[pick+1] = 1'b1;
            tbl_owner[pick+1] = '0;
            tbl_count++;
          end
        end
        if (ok) begin
          tbl_len[pick] = w.request_size;
          tbl_free[pick] = 1'b0;
          tbl_owner[pick] = w.owner_id;
          r.granted = 1'b1;
          r.start_block = tbl_start[pick];
          r.chosen_index = pick[6:0];
        end
      end
    end
    r.partitions_used = tbl_count;
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (calm || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result checker and receiver stall pattern
  always @(posedge clk) begin
    cpa_out_t want;
    int roll;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (alloc_results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: granted=%0d start=%0d index=%0d used=%0d",
                   rsp.granted, rsp.start_block, rsp.chosen_index, rsp.partitions_used);
      end else begin
        want = alloc_results_due.pop_front();
        if (rsp.granted !== want.granted || rsp.start_block !== want.start_block ||
            rsp.chosen_index !== want.chosen_index ||
            rsp.partitions_used !== want.partitions_used) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                     want.granted, want.start_block, want.chosen_index,
                     want.partitions_used, rsp.granted, rsp.start_block,
                     rsp.chosen_index, rsp.partitions_used);
        end
      end
    end
    if (calm) begin
      stall_left = 0;
      rsp_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
      roll = $urandom_range(99);
      if (roll < 20) stall_left = $urandom_range(1, 3);
      else if (roll < 23) stall_left = $urandom_range(20, 60);
      else stall_left = 0;
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  task automatic send_word(input logic cmd, input logic [7:0] size, input logic [7:0] owner);
    cpa_in_t w;
    int gap;
    w.command = cmd;
    w.request_size = size;
    w.owner_id = owner;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= w;
    do @(posedge clk); while (req_stall);
    alloc_results_due.push_back(apply_request(w));
  endtask

  // sender holds off until every outstanding word has come back
  task automatic wait_drain();
    req_valid <= 1'b0;
    while (alloc_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_fit_mode(input logic [31:0] value);
    wait_drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_FIT_MODE, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    fit_sel = value[1:0];
  endtask

  task automatic test_edge_sizes();
    write_fit_mode({30'd0, FIT_FIRST});
    send_word(CMD_ALLOC, 8'd0, 8'h00);
    send_word(CMD_ALLOC, 8'd255, 8'hFF);
    send_word(CMD_ALLOC, 8'd129, 8'h7F);
    send_word(CMD_ALLOC, 8'd128, 8'hA5);
    send_word(CMD_ALLOC, 8'd1, 8'h5A);
    send_word(CMD_REINIT, 8'hFF, 8'hFF);
    send_word(CMD_ALLOC, 8'd1, 8'h01);
    send_word(CMD_ALLOC, 8'd127, 8'h80);
    send_word(CMD_REINIT, 8'h00, 8'h00);
    send_word(CMD_ALLOC, 8'd64, 8'h3C);
    send_word(CMD_ALLOC, 8'd64, 8'hC3);
    send_word(CMD_ALLOC, 8'd1, 8'h99);
  endtask

  task automatic test_fit_modes();
    logic [1:0] modes [3];
    modes = '{FIT_BEST, FIT_WORST, FIT_SPARE};
    foreach (modes[m]) begin
      write_fit_mode({$urandom_range(0, 1) ? 30'h3FFF_FFFF : 30'd0, modes[m]});
      send_word(CMD_REINIT, 8'd0, 8'd0);
      send_word(CMD_ALLOC, 8'd10, 8'h11);
      send_word(CMD_ALLOC, 8'd100, 8'h22);
      send_word(CMD_ALLOC, 8'd30, 8'h44);
      send_word(CMD_ALLOC, 8'd18, 8'h88);
    end
  endtask

  // mostly single-block requests drive the table toward its full depth
  task automatic test_table_fill();
    write_fit_mode({30'd0, FIT_FIRST});
    send_word(CMD_REINIT, 8'h80, 8'h01);
    for (int n = 0; n < 130; n++) begin
      calm = (n >= 60 && n < 80);
      send_word(CMD_ALLOC, ($urandom_range(9) == 0) ? 8'd2 : 8'd1, 8'($urandom_range(255)));
    end
    calm = 1'b0;
  endtask

  task automatic test_random_mix();
    logic [1:0] modes [5];
    logic [7:0] size;
    int roll;
    modes = '{FIT_BEST, FIT_WORST, FIT_SPARE, FIT_FIRST, FIT_WORST};
    foreach (modes[p]) begin
      write_fit_mode({$urandom_range(0, 1) ? 30'($urandom) : 30'd0, modes[p]});
      send_word(CMD_REINIT, 8'($urandom_range(255)), 8'($urandom_range(255)));
      for (int n = 0; n < 60; n++) begin
        calm = (n >= 20 && n < 35);
        roll = $urandom_range(99);
        if (roll < 3) begin
          send_word(CMD_REINIT, 8'($urandom_range(255)), 8'($urandom_range(255)));
        end else begin
          roll = $urandom_range(99);
          if (roll < 70) size = 8'($urandom_range(1, 4));
          else if (roll < 85) size = 8'($urandom_range(5, 24));
          else if (roll < 90) size = 8'($urandom_range(25, 128));
          else if (roll < 95) size = 8'($urandom_range(129, 255));
          else size = 8'd0;
          send_word(CMD_ALLOC, size, 8'($urandom_range(255)));
        end
      end
      calm = 1'b0;
    end
  endtask

  initial begin
    fit_sel = FIT_FIRST;
    table_reset();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_edge_sizes();
    test_fit_modes();
    test_table_fill();
    test_random_mix();
    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && alloc_results_due.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/cpa_pkg.sv
design/cpa_cell.sv
design/contiguous_partition_allocator_core.sv
dv/testbench.sv
